// ----- rtl/gsp_pkg.sv -----
`timescale 1ns / 1ps
package gsp_pkg;

  localparam int unsigned PACKET_BITS = 36;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned TIME_W      = 16;
  localparam int unsigned WAIT_W      = 10;
  localparam int unsigned WORD_W      = 25;

  localparam logic [PACKET_BITS-1:0] SYNC_MASK  = 36'h04104107f;
  localparam logic [PACKET_BITS-1:0] SYNC_VALUE = 36'h041041040;
  localparam logic [CNT_W-1:0]       CNT_FULL   = CNT_W'(PACKET_BITS);
  localparam logic [TIME_W-1:0]      TIME_MAX   = '1;
  localparam logic [WAIT_W-1:0]      WAIT_RESET = 10'd100;
  localparam logic [3:0]             DEV_STD    = 4'd8;

  // Register index decoded from paddr[2]
  localparam logic REG_FIRST_STROBE_WAIT = 1'b0;

  // One finished capture: both channel buffers and their full flags
  typedef struct packed {
    logic [1:0][PACKET_BITS-1:0] bits;
    logic [1:0]                  full;
  } capture_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SEARCH,
    B_PUT
  } back_state_t;

  typedef struct packed {
    logic              ok;
    logic [WORD_W-1:0] word;
    logic [3:0]        dev;
    logic signed [1:0] ax;
    logic signed [1:0] ay;
    logic [11:0]       btn;
  } decode_t;

  function automatic logic sync_hit(input logic [PACKET_BITS-1:0] b);
    sync_hit = ((b & SYNC_MASK) == SYNC_VALUE);
  endfunction

  function automatic logic [PACKET_BITS-1:0] rot_right(input logic [PACKET_BITS-1:0] b);
    rot_right = {b[0], b[PACKET_BITS-1:1]};
  endfunction

  function automatic decode_t decode(input logic [PACKET_BITS-1:0] b, input logic full);
    decode_t d;
    logic [WORD_W-1:0] w;
    w = {b[35:31], b[29:25], b[23:19], b[17:13], b[11:7]};
    d.ok   = full & sync_hit(b);
    d.word = w;
    d.dev  = w[0] ? {1'b0, w[4:2]} : DEV_STD;
    d.ax   = $signed({1'b0, w[4]}) - $signed({1'b0, w[3]});
    d.ay   = $signed({1'b0, w[2]}) - $signed({1'b0, w[1]});
    d.btn  = {w[6:5], w[16:15], w[8:7], w[11:9], w[14:12]};
    if (!full) begin
      d = '0;
    end
    decode = d;
  endfunction

endpackage

// ----- rtl/gsp_front.sv -----
`timescale 1ns / 1ps
module gsp_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic [7:0]                        port_bits,
  input  logic [gsp_pkg::WAIT_W-1:0]        first_strobe_wait,
  input  logic                              q_full,
  output logic                              push,
  output gsp_pkg::capture_t                 push_data
);

  logic                                       capturing, capturing_next;
  logic [3:0]                                 refl, refl_next;
  logic [1:0][gsp_pkg::CNT_W-1:0]             cnt, cnt_next;
  logic [1:0][gsp_pkg::TIME_W-1:0]            tl, tl_next;
  logic [1:0][gsp_pkg::TIME_W-1:0]            mark, mark_next;
  logic [1:0][gsp_pkg::PACKET_BITS-1:0]       shreg, shreg_next;
  logic [3:0]                                 lines, diff;
  logic [1:0][gsp_pkg::TIME_W-1:0]            tl_dec, gap;
  logic [1:0][gsp_pkg::TIME_W:0]              reload;
  logic [1:0]                                 take;
  logic                                       accepted;

  assign in_ready = !q_full;
  assign accepted = in_valid && in_ready;
  assign lines    = port_bits[7:4];
  assign diff     = refl ^ lines;

  always_comb begin
    capturing_next = capturing;
    refl_next      = refl;
    cnt_next       = cnt;
    tl_next        = tl;
    mark_next      = mark;
    shreg_next     = shreg;
    take           = '0;
    push           = 1'b0;
    for (int i = 0; i < 2; i++) begin
      tl_dec[i] = (tl[i] != '0) ? tl[i] - 1'b1 : '0;
      gap[i]    = mark[i] - tl_dec[i];
      reload[i] = {gap[i], 1'b0};
    end
    if (accepted && req_type) begin
      // restart: latch reference, arm both channel timeouts
      capturing_next = 1'b1;
      refl_next      = lines;
      for (int i = 0; i < 2; i++) begin
        cnt_next[i]   = '0;
        shreg_next[i] = '0;
        tl_next[i]    = gsp_pkg::TIME_W'(first_strobe_wait);
        mark_next[i]  = gsp_pkg::TIME_W'({first_strobe_wait, 1'b0});
      end
    end else if (accepted && capturing) begin
      for (int i = 0; i < 2; i++) begin
        tl_next[i] = tl_dec[i];
        if (diff[2*i +: 2] != 2'b00) begin
          if (diff[2*i +: 2] != 2'b11 && cnt[i] < gsp_pkg::CNT_FULL && tl_dec[i] != '0) begin
            take[i]                  = 1'b1;
            shreg_next[i][cnt[i]]    = diff[2*i+1];
            cnt_next[i]              = cnt[i] + 1'b1;
            tl_next[i]   = reload[i][gsp_pkg::TIME_W] ? gsp_pkg::TIME_MAX
                                                      : reload[i][gsp_pkg::TIME_W-1:0];
            mark_next[i] = tl_next[i];
          end else begin
            tl_next[i] = '0;
          end
        end
      end
      if (take != '0) begin
        refl_next = lines;
      end
      if (tl_next[0] == '0 && tl_next[1] == '0) begin
        capturing_next = 1'b0;
        push           = 1'b1;
      end
    end
    for (int i = 0; i < 2; i++) begin
      push_data.bits[i] = shreg_next[i];
      push_data.full[i] = (cnt_next[i] == gsp_pkg::CNT_FULL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capturing <= 1'b0;
      refl      <= '0;
      cnt       <= '0;
      tl        <= '0;
      mark      <= '0;
      shreg     <= '0;
    end else begin
      capturing <= capturing_next;
      refl      <= refl_next;
      cnt       <= cnt_next;
      tl        <= tl_next;
      mark      <= mark_next;
      shreg     <= shreg_next;
    end
  end

endmodule

// ----- rtl/gsp_queue.sv -----
`timescale 1ns / 1ps
module gsp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  gsp_pkg::capture_t push_data,
  output logic              full,
  input  logic              pop,
  output gsp_pkg::capture_t pop_data,
  output logic              not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  gsp_pkg::capture_t mem [DEPTH];
  logic [PTR_W-1:0]  wp, rp;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PTR_W'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == PTR_W'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/gsp_back.sv -----
`timescale 1ns / 1ps
module gsp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  gsp_pkg::capture_t             q_data,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          channel,
  output logic                          packet_ok,
  output logic [24:0]                   raw_word,
  output logic [3:0]                    device_type,
  output logic signed [1:0]             axis_x,
  output logic signed [1:0]             axis_y,
  output logic [11:0]                   button_bits,
  output logic                          last
);

  gsp_pkg::back_state_t            state, state_next;
  gsp_pkg::capture_t               ent;
  logic [gsp_pkg::PACKET_BITS-1:0] b;
  logic                            full;
  logic                            ch;
  logic [gsp_pkg::CNT_W-1:0]       j;
  logic                            load0, load1, rotate, load_out, out_free;
  gsp_pkg::decode_t                dec;

  assign out_free = !out_valid || out_ready;
  assign dec      = gsp_pkg::decode(b, full);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load0      = 1'b0;
    load1      = 1'b0;
    rotate     = 1'b0;
    load_out   = 1'b0;
    case (state)
      gsp_pkg::B_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          load0      = 1'b1;
          state_next = gsp_pkg::B_SEARCH;
        end
      end
      gsp_pkg::B_SEARCH: begin
        // after a full turn the buffer is back to its original order
        if (!full || gsp_pkg::sync_hit(b) || j == gsp_pkg::CNT_FULL) begin
          state_next = gsp_pkg::B_PUT;
        end else begin
          rotate = 1'b1;
        end
      end
      gsp_pkg::B_PUT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (!ch) begin
            load1      = 1'b1;
            state_next = gsp_pkg::B_SEARCH;
          end else begin
            state_next = gsp_pkg::B_IDLE;
          end
        end
      end
      default: begin
        state_next = gsp_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gsp_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load0) begin
      ent  <= q_data;
      b    <= q_data.bits[0];
      full <= q_data.full[0];
      ch   <= 1'b0;
      j    <= '0;
    end else if (load1) begin
      b    <= ent.bits[1];
      full <= ent.full[1];
      ch   <= 1'b1;
      j    <= '0;
    end else if (rotate) begin
      b <= gsp_pkg::rot_right(b);
      j <= j + 1'b1;
    end
    if (load_out) begin
      channel     <= ch;
      last        <= ch;
      packet_ok   <= dec.ok;
      raw_word    <= dec.word;
      device_type <= dec.dev;
      axis_x      <= dec.ax;
      axis_y      <= dec.ay;
      button_bits <= dec.btn;
    end
  end

endmodule

// ----- rtl/gamepad_serial_packet_receiver.sv -----
`timescale 1ns / 1ps
// Channel   | Handshake              | Beat payload
// ----------+------------------------+---------------------------------------------
// sample in | in_valid / in_ready    | req_type, port_bits
// result    | out_valid / out_ready  | channel, packet_ok, raw_word, device_type,
//           |                        | axis_x, axis_y, button_bits, last
// config    | APB psel/penable/...   | first_strobe_wait at byte address 0
//
// Cycles: the capture front takes one sample beat per cycle. A capture that
// ends is pushed into a QUEUE_DEPTH-entry queue; in_ready drops only while
// that queue is full. The back end searches each channel for its sync
// pattern by rotating one bit per cycle, and it pops no new capture until
// both result beats of the current one are out; the single-bit rotator
// sets the result rate.
// Reset: synchronous, active high; clears the capture, the queue and the
// result stage and returns first_strobe_wait to 100. No clearing pass.
// Stalls: a held result beat (out_ready low) stalls only the back end; the
// front keeps sampling until the queue fills.
module gamepad_serial_packet_receiver #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  // sample channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic [7:0]        port_bits,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic              channel,
  output logic              packet_ok,
  output logic [24:0]       raw_word,
  output logic [3:0]        device_type,
  output logic signed [1:0] axis_x,
  output logic signed [1:0] axis_y,
  output logic [11:0]       button_bits,
  output logic              last,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [gsp_pkg::WAIT_W-1:0] first_strobe_wait;
  logic                       cfg_wr;
  logic                       q_full, q_push, q_pop, q_valid;
  gsp_pkg::capture_t          q_in, q_out;

  // Register file: a single register, decoded from paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == gsp_pkg::REG_FIRST_STROBE_WAIT);
  assign prdata = (paddr[2] == gsp_pkg::REG_FIRST_STROBE_WAIT)
                  ? {22'd0, first_strobe_wait} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_strobe_wait <= gsp_pkg::WAIT_RESET;
    end else if (cfg_wr) begin
      first_strobe_wait <= pwdata[gsp_pkg::WAIT_W-1:0];
    end
  end

  // Front: track line changes, shift in bits, run the timeouts
  gsp_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .req_type          (req_type),
    .port_bits         (port_bits),
    .first_strobe_wait (first_strobe_wait),
    .q_full            (q_full),
    .push              (q_push),
    .push_data         (q_in)
  );

  // Hold finished captures so the front waits on the result side only while the queue is full
  gsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_valid)
  );

  // Back: sync search, decode, and the registered result beat
  gsp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_out),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .channel     (channel),
    .packet_ok   (packet_ok),
    .raw_word    (raw_word),
    .device_type (device_type),
    .axis_x      (axis_x),
    .axis_y      (axis_y),
    .button_bits (button_bits),
    .last        (last)
  );

endmodule

// ----- rtl/gsp_checker.sv -----
`timescale 1ns / 1ps
module gsp_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              channel,
  input logic              packet_ok,
  input logic [24:0]       raw_word,
  input logic [3:0]        device_type,
  input logic              last,
  input logic [31:0]       prdata
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(channel) && $stable(raw_word)
                                && $stable(packet_ok))
    else $error("result beat changed while stalled");

  a_last_tracks_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == channel))
    else $error("last does not mark the second channel");

  // a short packet reports all zero, so only a synced full packet is checked
  a_std_pad_type: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_ok && !raw_word[0] |-> (device_type == 4'd8))
    else $error("standard pad not reported as type 8");

  a_reg_upper_zero: assert property (@(posedge clk)
    prdata[31:10] == 22'd0)
    else $error("register read shows bits above the field");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind gamepad_serial_packet_receiver gsp_checker u_gsp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .channel     (channel),
  .packet_ok   (packet_ok),
  .raw_word    (raw_word),
  .device_type (device_type),
  .last        (last),
  .prdata      (prdata)
);
